[design/ifpbc_pkg.sv]
// ----------------------------------------------------------------------------
// ifpbc_pkg
// Shared types, constants and the bucket hash for the IPv4 flow counter.
// ----------------------------------------------------------------------------
package ifpbc_pkg;

   localparam int TABLE_ENTRIES = 1024;
   localparam int BUCKETS       = 2 * TABLE_ENTRIES;
   localparam int BKT_W         = $clog2(BUCKETS);
   localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
   localparam int USED_W        = SLOT_W + 1;

   localparam logic [15:0] ETHERTYPE_IPV4    = 16'h0800;
   localparam logic [15:0] ETH_IP4_HDR_BYTES = 16'd34;

   typedef enum logic [1:0] {
      ST_SKIPPED  = 2'd0,
      ST_UPDATED  = 2'd1,
      ST_INSERTED = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   typedef struct packed {
      logic [15:0] captured_len;
      logic [15:0] ether_type;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic        direction;
      logic [15:0] pkt_len;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [9:0]  slot;
      logic [63:0] packets_now;
      logic [63:0] bytes_now;
   } rsp_type;

   typedef struct packed {
      logic             skip;
      logic             direction;
      logic [63:0]      key;
      logic [15:0]      pkt_len;
      logic [BKT_W-1:0] hash;
   } job_type;

   typedef struct packed {
      logic              valid;
      logic              direction;
      logic [63:0]       key;
      logic [SLOT_W-1:0] slot;
      logic [63:0]       packets;
      logic [63:0]       bytes;
   } bucket_type;

   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_READ,
      BK_CHECK
   } back_state_type;

   // Folds the key and direction onto the bucket index width by XOR.
   function automatic logic [BKT_W-1:0] bucket_hash(input logic [63:0] key,
                                                    input logic        dir);
      logic [64:0]      v;
      logic [BKT_W-1:0] h;
      v = {dir, key};
      h = '0;
      for (int i = 0; i < 65; i++) begin
         h[i % BKT_W] = h[i % BKT_W] ^ v[i];
      end
      return h;
   endfunction

endpackage

[design/ifpbc_front.sv]
// ----------------------------------------------------------------------------
// ifpbc_front
// Accepts requests, classifies them and queues them for the table engine.
// ----------------------------------------------------------------------------
module ifpbc_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  ifpbc_pkg::req_type  req_data,
   output logic                job_valid,
   input  logic                job_pop,
   output ifpbc_pkg::job_type  job_data
);

   ifpbc_pkg::job_type q_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;
   ifpbc_pkg::job_type job_new;
   logic               push;
   logic               pop;

   always_comb begin
      job_new.skip      = (req_data.captured_len < ifpbc_pkg::ETH_IP4_HDR_BYTES) ||
                          (req_data.ether_type != ifpbc_pkg::ETHERTYPE_IPV4);
      job_new.direction = req_data.direction;
      job_new.key       = {req_data.src_addr, req_data.dst_addr};
      job_new.pkt_len   = req_data.pkt_len;
      job_new.hash      = ifpbc_pkg::bucket_hash(job_new.key, req_data.direction);
   end

   assign req_ready = (count_ff != 2'd2);
   assign job_valid = (count_ff != 2'd0);
   assign job_data  = q_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = job_pop && job_valid;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= job_new;
      end
   end

endmodule

[design/ifpbc_back.sv]
// ----------------------------------------------------------------------------
// ifpbc_back
// Clears the bucket memory after reset, then probes it by hash, updates or
// inserts counters, and holds the response register.
// ----------------------------------------------------------------------------
module ifpbc_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                job_valid,
   output logic                job_pop,
   input  ifpbc_pkg::job_type  job_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output ifpbc_pkg::rsp_type  rsp_data
);

   ifpbc_pkg::bucket_type mem [ifpbc_pkg::BUCKETS];

   ifpbc_pkg::back_state_type state_ff, state_in;
   logic [ifpbc_pkg::BKT_W-1:0]  clr_ff, clr_in;
   logic [ifpbc_pkg::BKT_W-1:0]  probe_ff, probe_in;
   logic [ifpbc_pkg::USED_W-1:0] used_ff, used_in;
   ifpbc_pkg::job_type           job_ff, job_in;
   ifpbc_pkg::bucket_type        rd_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   ifpbc_pkg::rsp_type           rsp_ff, rsp_in;
   logic                         rsp_free;
   logic                         wr_en;
   logic [ifpbc_pkg::BKT_W-1:0]  wr_addr;
   ifpbc_pkg::bucket_type        wr_data;
   logic                         match;
   logic [63:0]                  pkts_inc;
   logic [63:0]                  bytes_inc;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign match     = rd_ff.valid && (rd_ff.key == job_ff.key) &&
                      (rd_ff.direction == job_ff.direction);
   assign pkts_inc  = rd_ff.packets + 64'd1;
   assign bytes_inc = rd_ff.bytes + {48'd0, job_ff.pkt_len};

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      probe_in     = probe_ff;
      used_in      = used_ff;
      job_in       = job_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      job_pop      = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = probe_ff;
      wr_data      = '0;
      unique case (state_ff)
         ifpbc_pkg::BK_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == ifpbc_pkg::BKT_W'(ifpbc_pkg::BUCKETS - 1)) begin
               state_in = ifpbc_pkg::BK_IDLE;
            end
         end
         ifpbc_pkg::BK_IDLE: begin
            if (job_valid && rsp_free) begin
               job_pop = 1'b1;
               job_in  = job_data;
               if (job_data.skip) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{ifpbc_pkg::ST_SKIPPED, 10'd0, 64'd0, 64'd0};
               end else begin
                  probe_in = job_data.hash;
                  state_in = ifpbc_pkg::BK_READ;
               end
            end
         end
         ifpbc_pkg::BK_READ: begin
            state_in = ifpbc_pkg::BK_CHECK;
         end
         ifpbc_pkg::BK_CHECK: begin
            if (match) begin
               wr_en         = 1'b1;
               wr_data       = rd_ff;
               wr_data.packets = pkts_inc;
               wr_data.bytes = bytes_inc;
               rsp_valid_in  = 1'b1;
               rsp_in        = '{ifpbc_pkg::ST_UPDATED, 10'(rd_ff.slot), pkts_inc, bytes_inc};
               state_in      = ifpbc_pkg::BK_IDLE;
            end else if (!rd_ff.valid) begin
               rsp_valid_in = 1'b1;
               state_in     = ifpbc_pkg::BK_IDLE;
               if (used_ff >= ifpbc_pkg::USED_W'(ifpbc_pkg::TABLE_ENTRIES)) begin
                  rsp_in = '{ifpbc_pkg::ST_FULL, 10'd0, 64'd0, 64'd0};
               end else begin
                  wr_en             = 1'b1;
                  wr_data.valid     = 1'b1;
                  wr_data.direction = job_ff.direction;
                  wr_data.key       = job_ff.key;
                  wr_data.slot      = used_ff[ifpbc_pkg::SLOT_W-1:0];
                  wr_data.packets   = 64'd1;
                  wr_data.bytes     = {48'd0, job_ff.pkt_len};
                  used_in           = used_ff + 1'b1;
                  rsp_in = '{ifpbc_pkg::ST_INSERTED, 10'(used_ff[ifpbc_pkg::SLOT_W-1:0]),
                             64'd1, {48'd0, job_ff.pkt_len}};
               end
            end else begin
               probe_in = probe_ff + 1'b1;
               state_in = ifpbc_pkg::BK_READ;
            end
         end
         default: begin
            state_in = ifpbc_pkg::BK_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ifpbc_pkg::BK_CLEAR;
         clr_ff       <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      probe_ff <= probe_in;
      job_ff   <= job_in;
      rsp_ff   <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[probe_ff];
   end

endmodule

[design/ipv4_flow_packet_byte_counter_core.sv]
// ----------------------------------------------------------------------------
// ipv4_flow_packet_byte_counter_core
// Per-flow packet and byte counters for IPv4 traffic, keyed on source,
// destination and direction.
// ----------------------------------------------------------------------------
// Each request on req_* carries one packet descriptor; each one produces
// exactly one response on rsp_* with a status, the entry slot and the
// updated packet and byte counts. Both channels use valid/ready.
// Requests that are too short or not IPv4 are answered as skipped.
// Other requests are looked up in a hash table of twice as many buckets as
// flow entries, with linear probing; each probe is a memory read, then a
// compare and write back. A skipped request is answered from the idle
// state; a counted one passes through the read and check states once per
// probe before its response is registered.
// A two-deep request queue sits in front of the engine, so requests keep
// being accepted while a response waits in the output register.
// After reset the engine sweeps all 2048 buckets of the memory, one bucket
// per cycle; requests are queued but not processed until the sweep ends.
// When rsp_ready is low the response register holds and the engine stops
// at its next response; the queue then fills and req_ready drops.
// ----------------------------------------------------------------------------
module ipv4_flow_packet_byte_counter_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  ifpbc_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output ifpbc_pkg::rsp_type rsp_data
);

   // Queue between the classifier and the table engine.
   logic               job_valid;
   logic               job_pop;
   ifpbc_pkg::job_type job_data;

   // Front: request acceptance, header checks, key hashing and queueing.
   ifpbc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .job_valid (job_valid),
      .job_pop   (job_pop),
      .job_data  (job_data)
   );

   // Back: bucket probing, counter update or insert, response register.
   ifpbc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_pop   (job_pop),
      .job_data  (job_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

[sim/tb_ipv4_flow_packet_byte_counter_core.sv]
// ----------------------------------------------------------------------------
// tb_ipv4_flow_packet_byte_counter_core
// Self-checking bench for the IPv4 per-flow counter. Requests of mostly valid
// IPv4 flows drawn from a small flow pool, with skipped and filler traffic,
// are driven in bursts and checked in order against an in-bench flow table.
// ----------------------------------------------------------------------------
module tb_ipv4_flow_packet_byte_counter_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_REQS = 1050;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   ifpbc_pkg::req_type req_data = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   ifpbc_pkg::rsp_type rsp_data;

   ipv4_flow_packet_byte_counter_core u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   // Bench copy of the flow table. Only valid entries are ever read.
   logic [63:0] flow_key   [ifpbc_pkg::TABLE_ENTRIES];
   logic        flow_dir   [ifpbc_pkg::TABLE_ENTRIES];
   logic [63:0] flow_pkts  [ifpbc_pkg::TABLE_ENTRIES];
   logic [63:0] flow_bytes [ifpbc_pkg::TABLE_ENTRIES];
   int          flows_used = 0;

   ifpbc_pkg::req_type pending_reqs[$];     // requests waiting for the driver
   ifpbc_pkg::rsp_type expected_rsps[$];    // predicted responses in request order
   int      mismatches = 0;
   int      cycles = 0;
   bit      stim_done = 1'b0;
   bit      hold_rx = 1'b0;      // long receiver hold-off
   bit      pause_tx = 1'b0;     // sender waits for a drained pipeline

   // Computes the response for one request and updates the bench table.
   function automatic ifpbc_pkg::rsp_type count_packet(ifpbc_pkg::req_type r);
      ifpbc_pkg::rsp_type o;
      logic [63:0]        k;
      o = '0;
      o.status = ifpbc_pkg::ST_SKIPPED;
      k = {r.src_addr, r.dst_addr};
      if (r.captured_len < 16'd14 || r.ether_type != ifpbc_pkg::ETHERTYPE_IPV4 ||
          r.captured_len < ifpbc_pkg::ETH_IP4_HDR_BYTES)
         return o;
      for (int i = 0; i < flows_used; i++) begin
         if (flow_key[i] == k && flow_dir[i] == r.direction) begin
            flow_pkts[i]  = flow_pkts[i] + 64'd1;
            flow_bytes[i] = flow_bytes[i] + 64'(r.pkt_len);
            o.status = ifpbc_pkg::ST_UPDATED;
            o.slot = 10'(i);
            o.packets_now = flow_pkts[i];
            o.bytes_now = flow_bytes[i];
            return o;
         end
      end
      if (flows_used >= ifpbc_pkg::TABLE_ENTRIES) begin
         o.status = ifpbc_pkg::ST_FULL;
         return o;
      end
      flow_key[flows_used] = k;
      flow_dir[flows_used] = r.direction;
      flow_pkts[flows_used] = 64'd1;
      flow_bytes[flows_used] = 64'(r.pkt_len);
      o.status = ifpbc_pkg::ST_INSERTED;
      o.slot = 10'(flows_used);
      o.packets_now = 64'd1;
      o.bytes_now = 64'(r.pkt_len);
      flows_used++;
      return o;
   endfunction

   function automatic ifpbc_pkg::req_type make_req(logic [15:0] cap, logic [15:0] et,
                                                   logic [31:0] s, logic [31:0] d,
                                                   logic dir, logic [15:0] len);
      ifpbc_pkg::req_type r;
      r.captured_len = cap; r.ether_type = et; r.src_addr = s;
      r.dst_addr = d; r.direction = dir; r.pkt_len = len;
      return r;
   endfunction

   task automatic push_req(ifpbc_pkg::req_type r);
      pending_reqs.push_back(r);
      expected_rsps.push_back(count_packet(r));
   endtask

   // Driver: bursts of random length separated by random gaps. Valid is held
   // with a stable payload until the request is taken.
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) void'(pending_reqs.pop_front());
         if (req_valid && !req_ready) begin
            // Keep offering the same request.
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pause_tx || pending_reqs.size() == 0) begin
            req_valid <= 1'b0;
         end else begin
            req_valid <= 1'b1;
            req_data <= pending_reqs[0];
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 40);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               burst_left <= burst_left - 1;
            end
         end
      end
   end

   // Monitor and receiver stall pattern. The pattern alternates stretches of
   // full readiness with stretches of random stalls.
   int stall_phase = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response %p", rsp_data);
            end else if (rsp_data !== expected_rsps[0]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p, got %p", expected_rsps[0], rsp_data);
               void'(expected_rsps.pop_front());
            end else begin
               void'(expected_rsps.pop_front());
            end
         end
         stall_phase <= (stall_phase + 1) % 600;
         if (hold_rx) rsp_ready <= 1'b0;
         else if (stall_phase < 300) rsp_ready <= 1'b1;
         else rsp_ready <= ($urandom_range(0, 2) != 0);
      end
      if (cycles >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Long receiver hold-off counted in its own process.
   initial begin
      int n;
      wait (stim_done == 1'b0 && pending_reqs.size() > 200);
      repeat (3000) @(posedge clock);
      hold_rx = 1'b1;
      for (n = 0; n < 400; n++) @(posedge clock);
      hold_rx = 1'b0;
   end

   initial begin
      logic [31:0]        pool_s[16];
      logic [31:0]        pool_d[16];
      int                 pick;
      int                 kind;
      ifpbc_pkg::req_type r;
      for (int i = 0; i < 16; i++) begin
         pool_s[i] = $urandom; pool_d[i] = $urandom;
      end
      // Directed: length thresholds, ethertype, extremes, hit/miss, directions.
      push_req(make_req(16'd0, ifpbc_pkg::ETHERTYPE_IPV4, 32'h1, 32'h2, 1'b0, 16'd100));
      push_req(make_req(16'd13, ifpbc_pkg::ETHERTYPE_IPV4, 32'h1, 32'h2, 1'b0, 16'd100));
      push_req(make_req(16'd14, ifpbc_pkg::ETHERTYPE_IPV4, 32'h1, 32'h2, 1'b0, 16'd100));
      push_req(make_req(16'd33, ifpbc_pkg::ETHERTYPE_IPV4, 32'h1, 32'h2, 1'b0, 16'd100));
      push_req(make_req(16'd34, 16'h86DD, 32'h1, 32'h2, 1'b0, 16'd100));
      push_req(make_req(16'd34, 16'hFFFF, 32'h1, 32'h2, 1'b0, 16'd100));
      push_req(make_req(16'd34, ifpbc_pkg::ETHERTYPE_IPV4, 32'h1, 32'h2, 1'b0, 16'd0));
      push_req(make_req(16'd34, ifpbc_pkg::ETHERTYPE_IPV4, 32'h1, 32'h2, 1'b0, 16'hFFFF));
      push_req(make_req(16'hFFFF, ifpbc_pkg::ETHERTYPE_IPV4, 32'h1, 32'h2, 1'b1,
                        16'hFFFF));
      push_req(make_req(16'hFFFF, ifpbc_pkg::ETHERTYPE_IPV4, 32'h2, 32'h1, 1'b0, 16'd7));
      push_req(make_req(16'd60, ifpbc_pkg::ETHERTYPE_IPV4, 32'h0, 32'h0, 1'b0, 16'd1));
      push_req(make_req(16'd60, ifpbc_pkg::ETHERTYPE_IPV4, 32'hFFFFFFFF, 32'hFFFFFFFF,
                        1'b1, 16'hFFFF));
      push_req(make_req(16'd60, ifpbc_pkg::ETHERTYPE_IPV4, 32'hFFFFFFFF, 32'hFFFFFFFF,
                        1'b1, 16'hFFFF));
      push_req(make_req(16'd60, ifpbc_pkg::ETHERTYPE_IPV4, 32'h0, 32'h0, 1'b0, 16'd1));
      reset = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      // Random part: mostly valid flows from a small pool so hits dominate.
      for (int n = 0; n < RANDOM_REQS; n++) begin
         kind = $urandom_range(0, 99);
         pick = $urandom_range(0, 15);
         if (kind < 70)
            r = make_req(16'($urandom_range(34, 65535)), ifpbc_pkg::ETHERTYPE_IPV4,
                         pool_s[pick], pool_d[pick], 1'($urandom), 16'($urandom));
         else if (kind < 85)
            r = make_req(16'($urandom_range(34, 1600)), ifpbc_pkg::ETHERTYPE_IPV4,
                         $urandom, $urandom, 1'($urandom), 16'($urandom));
         else
            r = make_req(16'($urandom), 16'($urandom), $urandom, $urandom,
                         1'($urandom), 16'($urandom));
         push_req(r);
         if (n == 500) begin
            // Send everything queued so far, then hold off until the pipeline
            // has drained completely before going on.
            wait (pending_reqs.size() == 0);
            pause_tx = 1'b1;
            wait (expected_rsps.size() == 0);
            pause_tx = 1'b0;
         end
      end
      stim_done = 1'b1;
      wait (pending_reqs.size() == 0 && !req_valid);
      wait (expected_rsps.size() == 0);
      repeat (50) @(posedge clock);
      if (mismatches == 0 && expected_rsps.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

[files.f]
design/ifpbc_pkg.sv
design/ifpbc_front.sv
design/ifpbc_back.sv
design/ipv4_flow_packet_byte_counter_core.sv
sim/tb_ipv4_flow_packet_byte_counter_core.sv
